>>> hw/rtl/scl_pkg.sv
package scl_pkg;

    localparam int BYTE_W      = 8;
    localparam int DIGIT_W     = 4;
    localparam int MAG_W       = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_PULSE_W = 12;
    localparam int TIMEOUT_W   = 16;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    localparam logic [TIMEOUT_W-1:0] RST_TIMEOUT       = 16'd500;
    localparam int                   RST_PULSE_MIN     = 1000;
    localparam int                   RST_PULSE_MAX     = 2000;
    localparam int                   RST_PULSE_NEUTRAL = 1500;

    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_NL    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_VT    = 8'h0B;
    localparam logic [BYTE_W-1:0] CH_FF    = 8'h0C;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

    typedef enum logic {
        OP_BYTE,
        OP_TICK
    } opcode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIMEOUT,
        CFG_PULSE_MIN,
        CFG_PULSE_MAX,
        CFG_PULSE_NEUTRAL
    } cfg_idx_t;

    typedef enum logic [3:0] {
        KIND_TICK,
        KIND_NEWLINE,
        KIND_CR,
        KIND_COMMA,
        KIND_DIGIT,
        KIND_SPACE,
        KIND_PLUS,
        KIND_MINUS,
        KIND_OTHER
    } kind_t;

    typedef struct packed {
        kind_t               kind;
        logic [DIGIT_W-1:0]  digit;
    } item_t;

    typedef enum logic [1:0] {
        PH_SKIP,
        PH_SIGN,
        PH_DIGITS,
        PH_STOP
    } phase_t;

endpackage

>>> hw/rtl/servo_command_line_parser.sv
// An accepted item waits in the queue, then its result lands in the output register.
// The back end takes one item per cycle while the output register is empty or
// out_ready is high; a 2-entry queue separates it from the input classifier.
// Reset: limits 1000/2000 us, neutral 1500 us, timeout 500 ticks, both widths
// neutral, queue and output register empty.
module servo_command_line_parser #(
    parameter int PULSE_BITS = 12,
    parameter int TICK_BITS  = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             opcode,
    input  logic [scl_pkg::BYTE_W-1:0]       rx_byte,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [PULSE_BITS-1:0]            throttle_us,
    output logic [PULSE_BITS-1:0]            steering_us,
    output logic                             command_taken,
    output logic                             timed_out,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [scl_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [scl_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import scl_pkg::*;

    logic                q_push;
    item_t               q_push_item;
    logic                q_pop;
    item_t               q_item;
    logic                q_empty;
    logic                q_full;
    logic [Q_CNT_W-1:0]  q_count;

    assign cfg_ready = 1'b1;

    scl_front u_front (
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .rx_byte     (rx_byte),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_push_item (q_push_item)
    );

    scl_queue u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_push      (q_push),
        .q_push_item (q_push_item),
        .q_pop       (q_pop),
        .q_item      (q_item),
        .q_empty     (q_empty),
        .q_full      (q_full),
        .q_count     (q_count)
    );

    scl_back #(
        .PULSE_BITS (PULSE_BITS),
        .TICK_BITS  (TICK_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .q_empty       (q_empty),
        .q_item        (q_item),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .throttle_us   (throttle_us),
        .steering_us   (steering_us),
        .command_taken (command_taken),
        .timed_out     (timed_out)
    );

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("queue popped while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= Q_CNT_W'(Q_DEPTH))
        else $error("queue count above depth");

    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !q_empty)
        else $error("accepted item missing from queue");

    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(command_taken && timed_out))
        else $error("command and timeout flagged on one item");

endmodule

>>> hw/rtl/scl_front.sv
module scl_front (
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        opcode,
    input  logic [scl_pkg::BYTE_W-1:0]  rx_byte,
    input  logic                        q_full,
    output logic                        q_push,
    output scl_pkg::item_t              q_push_item
);
    import scl_pkg::*;

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    // byte classification; digit value is the low nibble of '0'..'9'
    always_comb
    begin
        q_push_item.digit = rx_byte[DIGIT_W-1:0];
        q_push_item.kind  = KIND_OTHER;
        if (opcode == OP_TICK)
        begin
            q_push_item.kind = KIND_TICK;
        end
        else
        begin
            unique case (rx_byte) inside
                CH_NL:                         q_push_item.kind = KIND_NEWLINE;
                CH_CR:                         q_push_item.kind = KIND_CR;
                CH_COMMA:                      q_push_item.kind = KIND_COMMA;
                CH_PLUS:                       q_push_item.kind = KIND_PLUS;
                CH_MINUS:                      q_push_item.kind = KIND_MINUS;
                CH_SPACE, CH_TAB, CH_VT, CH_FF: q_push_item.kind = KIND_SPACE;
                [CH_ZERO:CH_NINE]:             q_push_item.kind = KIND_DIGIT;
                default:                       q_push_item.kind = KIND_OTHER;
            endcase
        end
    end

endmodule

>>> hw/rtl/scl_queue.sv
module scl_queue (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_push,
    input  scl_pkg::item_t                q_push_item,
    input  logic                          q_pop,
    output scl_pkg::item_t                q_item,
    output logic                          q_empty,
    output logic                          q_full,
    output logic [scl_pkg::Q_CNT_W-1:0]   q_count
);
    import scl_pkg::*;

    item_t               entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0]  count_reg, count_next;

    assign q_item  = entry_reg[rd_ptr_reg];
    assign q_empty = (count_reg == '0);
    assign q_full  = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign q_count = count_reg;

    always_comb
    begin
        wr_ptr_next = q_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + Q_CNT_W'(q_push) - Q_CNT_W'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_push)
        begin
            entry_reg[wr_ptr_reg] <= q_push_item;
        end
    end

endmodule

>>> hw/rtl/scl_back.sv
module scl_back #(
    parameter int PULSE_BITS = 12,
    parameter int TICK_BITS  = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [scl_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [scl_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             q_empty,
    input  scl_pkg::item_t                   q_item,
    output logic                             q_pop,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [PULSE_BITS-1:0]            throttle_us,
    output logic [PULSE_BITS-1:0]            steering_us,
    output logic                             command_taken,
    output logic                             timed_out
);
    import scl_pkg::*;

    localparam int V_W   = MAG_W + 1;
    localparam int M10_W = MAG_W + 4;
    localparam int CMP_W = (TICK_BITS > TIMEOUT_W) ? TICK_BITS : TIMEOUT_W;

    logic [TIMEOUT_W-1:0]  timeout_reg, timeout_next;
    logic [PULSE_BITS-1:0] pmin_reg, pmin_next;
    logic [PULSE_BITS-1:0] pmax_reg, pmax_next;
    logic [PULSE_BITS-1:0] pneut_reg, pneut_next;

    logic                  after_comma_reg, after_comma_next;
    logic                  first_nonempty_reg, first_nonempty_next;
    phase_t                phase_reg, phase_next;
    logic                  negative_reg, negative_next;
    logic [MAG_W-1:0]      mag_reg, mag_next;
    logic [PULSE_BITS-1:0] pending_reg, pending_next;
    logic [PULSE_BITS-1:0] throttle_reg, throttle_next;
    logic [PULSE_BITS-1:0] steering_reg, steering_next;
    logic [TICK_BITS-1:0]  idle_reg, idle_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  taken_reg, taken_next;
    logic                  fired_reg, fired_next;

    phase_t                phase_fed;
    logic                  negative_fed;
    logic [MAG_W-1:0]      mag_fed;
    logic [M10_W-1:0]      mag_x10;
    logic [TICK_BITS-1:0]  idle_inc;
    logic [PULSE_BITS-1:0] number_clamped;

    function automatic logic [PULSE_BITS-1:0] clamp_value(
        input logic                  neg,
        input logic [MAG_W-1:0]      mag,
        input logic [PULSE_BITS-1:0] lo,
        input logic [PULSE_BITS-1:0] hi
    );
        logic signed [V_W-1:0] v;
        logic signed [V_W-1:0] lo_s;
        logic signed [V_W-1:0] hi_s;
        logic [PULSE_BITS-1:0] res;
        v    = signed'({1'b0, mag});
        lo_s = signed'(V_W'(lo));
        hi_s = signed'(V_W'(hi));
        if (neg)
        begin
            v = -v;
        end
        if (v < lo_s)
        begin
            res = lo;
        end
        else if (v > hi_s)
        begin
            res = hi;
        end
        else
        begin
            res = PULSE_BITS'(mag);
        end
        return res;
    endfunction

    assign q_pop         = !q_empty && (!out_valid_reg || out_ready);
    assign out_valid     = out_valid_reg;
    assign throttle_us   = throttle_reg;
    assign steering_us   = steering_reg;
    assign command_taken = taken_reg;
    assign timed_out     = fired_reg;

    assign number_clamped = clamp_value(negative_reg, mag_reg, pmin_reg, pmax_reg);
    assign idle_inc       = (&idle_reg) ? idle_reg : idle_reg + 1'b1;

    // atol-style parse: skip whitespace, optional sign, then saturating digit accumulation
    always_comb
    begin
        mag_x10      = M10_W'({mag_reg, 3'b000}) + M10_W'({mag_reg, 1'b0})
                       + M10_W'(q_item.digit);
        phase_fed    = phase_reg;
        negative_fed = negative_reg;
        mag_fed      = mag_reg;
        if (phase_reg != PH_STOP)
        begin
            if (phase_reg == PH_SKIP && q_item.kind == KIND_SPACE)
            begin
                phase_fed = PH_SKIP;
            end
            else if (phase_reg == PH_SKIP &&
                     (q_item.kind == KIND_PLUS || q_item.kind == KIND_MINUS))
            begin
                negative_fed = (q_item.kind == KIND_MINUS);
                phase_fed    = PH_SIGN;
            end
            else if (q_item.kind == KIND_DIGIT)
            begin
                mag_fed   = (mag_x10 > M10_W'({MAG_W{1'b1}})) ? {MAG_W{1'b1}}
                                                               : mag_x10[MAG_W-1:0];
                phase_fed = PH_DIGITS;
            end
            else
            begin
                phase_fed = PH_STOP;
            end
        end
    end

    always_comb
    begin
        timeout_next = timeout_reg;
        pmin_next    = pmin_reg;
        pmax_next    = pmax_reg;
        pneut_next   = pneut_reg;
        if (cfg_write)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_TIMEOUT:       timeout_next = cfg_data[TIMEOUT_W-1:0];
                CFG_PULSE_MIN:     pmin_next  = PULSE_BITS'(cfg_data[CFG_PULSE_W-1:0]);
                CFG_PULSE_MAX:     pmax_next  = PULSE_BITS'(cfg_data[CFG_PULSE_W-1:0]);
                CFG_PULSE_NEUTRAL: pneut_next = PULSE_BITS'(cfg_data[CFG_PULSE_W-1:0]);
                default:           timeout_next = timeout_reg;
            endcase
        end
    end

    always_comb
    begin
        after_comma_next    = after_comma_reg;
        first_nonempty_next = first_nonempty_reg;
        phase_next          = phase_reg;
        negative_next       = negative_reg;
        mag_next            = mag_reg;
        pending_next        = pending_reg;
        throttle_next       = throttle_reg;
        steering_next       = steering_reg;
        idle_next           = idle_reg;
        taken_next          = taken_reg;
        fired_next          = fired_reg;
        out_valid_next      = out_valid_reg && !out_ready;

        if (q_pop)
        begin
            out_valid_next = 1'b1;
            taken_next     = 1'b0;
            fired_next     = 1'b0;
            case (q_item.kind)
                KIND_TICK:
                begin
                    idle_next = idle_inc;
                    if (CMP_W'(idle_inc) > CMP_W'(timeout_reg))
                    begin
                        throttle_next = pneut_reg;
                        steering_next = pneut_reg;
                        fired_next    = 1'b1;
                    end
                end
                KIND_NEWLINE:
                begin
                    if (after_comma_reg && first_nonempty_reg)
                    begin
                        throttle_next = pending_reg;
                        steering_next = number_clamped;
                        idle_next     = '0;
                        taken_next    = 1'b1;
                    end
                    after_comma_next    = 1'b0;
                    first_nonempty_next = 1'b0;
                    pending_next        = '0;
                    phase_next          = PH_SKIP;
                    negative_next       = 1'b0;
                    mag_next            = '0;
                end
                KIND_CR:
                begin
                    idle_next = idle_reg;
                end
                default:
                begin
                    if (q_item.kind == KIND_COMMA && !after_comma_reg)
                    begin
                        after_comma_next = 1'b1;
                        if (first_nonempty_reg)
                        begin
                            pending_next = number_clamped;
                        end
                        phase_next    = PH_SKIP;
                        negative_next = 1'b0;
                        mag_next      = '0;
                    end
                    else
                    begin
                        if (!after_comma_reg)
                        begin
                            first_nonempty_next = 1'b1;
                        end
                        phase_next    = phase_fed;
                        negative_next = negative_fed;
                        mag_next      = mag_fed;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg        <= RST_TIMEOUT;
            pmin_reg           <= PULSE_BITS'(RST_PULSE_MIN);
            pmax_reg           <= PULSE_BITS'(RST_PULSE_MAX);
            pneut_reg          <= PULSE_BITS'(RST_PULSE_NEUTRAL);
            after_comma_reg    <= 1'b0;
            first_nonempty_reg <= 1'b0;
            phase_reg          <= PH_SKIP;
            negative_reg       <= 1'b0;
            mag_reg            <= '0;
            pending_reg        <= '0;
            throttle_reg       <= PULSE_BITS'(RST_PULSE_NEUTRAL);
            steering_reg       <= PULSE_BITS'(RST_PULSE_NEUTRAL);
            idle_reg           <= '0;
            out_valid_reg      <= 1'b0;
            taken_reg          <= 1'b0;
            fired_reg          <= 1'b0;
        end
        else
        begin
            timeout_reg        <= timeout_next;
            pmin_reg           <= pmin_next;
            pmax_reg           <= pmax_next;
            pneut_reg          <= pneut_next;
            after_comma_reg    <= after_comma_next;
            first_nonempty_reg <= first_nonempty_next;
            phase_reg          <= phase_next;
            negative_reg       <= negative_next;
            mag_reg            <= mag_next;
            pending_reg        <= pending_next;
            throttle_reg       <= throttle_next;
            steering_reg       <= steering_next;
            idle_reg           <= idle_next;
            out_valid_reg      <= out_valid_next;
            taken_reg          <= taken_next;
            fired_reg          <= fired_next;
        end
    end

endmodule

>>> bench/servo_command_line_parser_tb.sv
module servo_command_line_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import scl_pkg::*;

    localparam int PW = 12;
    localparam int TW = 16;

    typedef struct packed {
        logic [PW-1:0] throttle;
        logic [PW-1:0] steering;
        logic          taken;
        logic          fired;
    } servo_out_t;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic                  opcode;
    logic [BYTE_W-1:0]     rx_byte;
    logic                  out_valid;
    logic                  out_ready;
    logic [PW-1:0]         throttle_us;
    logic [PW-1:0]         steering_us;
    logic                  command_taken;
    logic                  timed_out;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    servo_command_line_parser uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .opcode        (opcode),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .throttle_us   (throttle_us),
        .steering_us   (steering_us),
        .command_taken (command_taken),
        .timed_out     (timed_out),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // limits as currently programmed
    logic [TW-1:0] lim_timeout;
    logic [PW-1:0] lim_min;
    logic [PW-1:0] lim_max;
    logic [PW-1:0] lim_neutral;

    // parser state
    logic          in_steer_part;
    logic          thr_seen;
    phase_t        num_phase;
    logic          num_neg;
    logic [15:0]   num_mag;
    logic [PW-1:0] pending_thr;
    logic [PW-1:0] thr_w;
    logic [PW-1:0] str_w;
    logic [TW-1:0] quiet_ticks;

    servo_out_t widths_due[$];
    int         items_sent;
    int         fails;
    logic       calm;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic void clear_number();
        num_phase = PH_SKIP;
        num_neg   = 1'b0;
        num_mag   = '0;
    endfunction

    function automatic void clear_line();
        in_steer_part = 1'b0;
        thr_seen      = 1'b0;
        pending_thr   = '0;
        clear_number();
    endfunction

    function automatic void feed_number(input logic [BYTE_W-1:0] c);
        logic is_digit;
        int   m;
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
        if (num_phase == PH_SKIP)
        begin
            if (c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF)
                return;
            if (c == CH_PLUS || c == CH_MINUS)
            begin
                num_neg   = (c == CH_MINUS);
                num_phase = PH_SIGN;
                return;
            end
            num_phase = PH_SIGN;
        end
        if (num_phase == PH_SIGN || num_phase == PH_DIGITS)
        begin
            if (is_digit)
            begin
                m = int'(num_mag) * 10 + int'(c - CH_ZERO);
                num_mag   = (m > 65535) ? 16'hFFFF : m[15:0];
                num_phase = PH_DIGITS;
            end
            else
                num_phase = PH_STOP;
        end
    endfunction

    function automatic logic [PW-1:0] clamp_width();
        int v;
        int lo;
        int hi;
        lo = lim_min;
        hi = lim_max;
        v  = num_neg ? -int'(num_mag) : int'(num_mag);
        if (v < lo)
            return lim_min;
        if (v > hi)
            return lim_max;
        return v[PW-1:0];
    endfunction

    function automatic servo_out_t advance_parser(input opcode_t op, input logic [BYTE_W-1:0] c);
        servo_out_t r;
        r.taken = 1'b0;
        r.fired = 1'b0;
        if (op == OP_BYTE)
        begin
            if (c == CH_NL)
            begin
                if (in_steer_part && thr_seen)
                begin
                    thr_w       = pending_thr;
                    str_w       = clamp_width();
                    quiet_ticks = '0;
                    r.taken     = 1'b1;
                end
                clear_line();
            end
            else if (c != CH_CR)
            begin
                if (!in_steer_part && c == CH_COMMA)
                begin
                    in_steer_part = 1'b1;
                    if (thr_seen)
                        pending_thr = clamp_width();
                    clear_number();
                end
                else
                begin
                    if (!in_steer_part)
                        thr_seen = 1'b1;
                    feed_number(c);
                end
            end
        end
        else
        begin
            if (quiet_ticks != '1)
                quiet_ticks++;
            if (quiet_ticks > lim_timeout)
            begin
                thr_w   = lim_neutral;
                str_w   = lim_neutral;
                r.fired = 1'b1;
            end
        end
        r.throttle = thr_w;
        r.steering = str_w;
        return r;
    endfunction

    task automatic send_item(input opcode_t op, input logic [BYTE_W-1:0] c);
        if (!calm && $urandom_range(0, 9) == 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14) - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        opcode   <= op;
        rx_byte  <= c;
        do @(posedge clk); while (!in_ready);
        widths_due.push_back(advance_parser(op, c));
        items_sent++;
    endtask

    task automatic send_tick();
        send_item(OP_TICK, BYTE_W'($urandom_range(0, 255)));
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_item(OP_BYTE, s[i]);
    endtask

    // content char, with a random tick slipped in now and then
    task automatic send_char(input logic [BYTE_W-1:0] c);
        if ($urandom_range(0, 9) == 0)
            send_tick();
        send_item(OP_BYTE, c);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_TIMEOUT:       lim_timeout = val;
            CFG_PULSE_MIN:     lim_min     = val[PW-1:0];
            CFG_PULSE_MAX:     lim_max     = val[PW-1:0];
            CFG_PULSE_NEUTRAL: lim_neutral = val[PW-1:0];
            default: ;
        endcase
    endtask

    task automatic set_limits(input logic [TW-1:0] t, input logic [PW-1:0] lo,
                              input logic [PW-1:0] hi, input logic [PW-1:0] mid);
        write_reg(CFG_TIMEOUT, t);
        write_reg(CFG_PULSE_MIN, CFG_DATA_W'(lo));
        write_reg(CFG_PULSE_MAX, CFG_DATA_W'(hi));
        write_reg(CFG_PULSE_NEUTRAL, CFG_DATA_W'(mid));
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_results_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (widths_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic send_number_text();
        logic [BYTE_W-1:0] ws[4];
        int                ndig;
        ws = '{CH_SPACE, CH_TAB, CH_VT, CH_FF};
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2)) send_char(ws[$urandom_range(0, 3)]);
        case ($urandom_range(0, 4))
            0: send_char(CH_MINUS);
            1: send_char(CH_PLUS);
            default: ;
        endcase
        ndig = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
        repeat (ndig) send_char(CH_ZERO + BYTE_W'($urandom_range(0, 9)));
        if ($urandom_range(0, 9) == 0)
            send_char(BYTE_W'($urandom_range(0, 255)));
    endtask

    task automatic send_random_line();
        case ($urandom_range(0, 9))
            0:
            begin
                repeat ($urandom_range(1, 8)) send_char(BYTE_W'($urandom_range(0, 255)));
                send_char(CH_NL);
            end
            1:
            begin
                send_char(CH_COMMA);
                send_number_text();
                send_char(CH_NL);
            end
            2:
            begin
                send_number_text();
                send_char(CH_NL);
            end
            default:
            begin
                send_number_text();
                if ($urandom_range(0, 7) == 0)
                    send_char(CH_CR);
                send_char(CH_COMMA);
                send_number_text();
                if ($urandom_range(0, 7) == 0)
                begin
                    send_char(CH_COMMA);
                    send_number_text();
                end
                if ($urandom_range(0, 3) == 0)
                    send_char(CH_CR);
                send_char(CH_NL);
            end
        endcase
    endtask

    task automatic pick_random_limits();
        logic [TW-1:0] t;
        logic [PW-1:0] lo;
        logic [PW-1:0] hi;
        logic [PW-1:0] mid;
        case ($urandom_range(0, 3))
            0:       t = TW'(1);
            1:       t = '1;
            default: t = TW'($urandom_range(1, 40));
        endcase
        lo = PW'($urandom_range(0, 2000));
        hi = PW'($urandom_range(lo, 4095));
        case ($urandom_range(0, 5))
            0: lo = '0;
            1: hi = '1;
            2: lo = '1;
            3: hi = '0;
            default: ;
        endcase
        mid = PW'($urandom);
        if ($urandom_range(0, 2) == 0)
            mid = $urandom_range(0, 1) ? '1 : '0;
        set_limits(t, lo, hi, mid);
    endtask

    task automatic test_line_syntax();
        // leading whitespace, signs, saturation, carriage return
        send_item(OP_BYTE, CH_SPACE);
        send_item(OP_BYTE, CH_TAB);
        send_item(OP_BYTE, CH_VT);
        send_item(OP_BYTE, CH_FF);
        send_text("+99999");
        send_item(OP_BYTE, CH_CR);
        send_text(",-0");
        send_item(OP_BYTE, CH_NL);
        // comma as first char, then a line without comma
        send_text(",9");
        send_item(OP_BYTE, CH_NL);
        send_text("7");
        send_item(OP_BYTE, CH_NL);
        // only the first comma splits
        send_text("1100,1900,5");
        send_item(OP_BYTE, CH_NL);
        // NUL and 0xFF are plain non-digits
        send_item(OP_BYTE, 8'h00);
        send_text("1,");
        send_item(OP_BYTE, 8'hFF);
        send_item(OP_BYTE, CH_NL);
        wait_results_drained();
    endtask

    task automatic test_clamp_timing();
        // throttle clamps with limits at the comma, steering with those at the newline
        send_text("3000,");
        wait_results_drained();
        set_limits(TW'(500), PW'(1000), PW'(2500), PW'(1500));
        send_text("3000");
        send_item(OP_BYTE, CH_NL);
        wait_results_drained();
        // min above max
        set_limits(TW'(500), PW'(3000), PW'(1000), PW'(1500));
        send_text("2000,-1");
        send_item(OP_BYTE, CH_NL);
        wait_results_drained();
    endtask

    task automatic test_timeout_fallback();
        set_limits(TW'(1), '0, '1, '1);
        send_text("4095,0");
        send_item(OP_BYTE, CH_NL);
        repeat (3) send_tick();
        wait_results_drained();
        set_limits(TW'(2), '0, '1, '0);
        repeat (2) send_tick();
        send_text("12,34");
        send_item(OP_BYTE, CH_NL);
        repeat (4) send_tick();
        wait_results_drained();
    endtask

    task automatic test_long_timeout();
        calm = 1'b1;
        set_limits('1, PW'(1000), PW'(2000), PW'(1500));
        repeat (20) send_tick();
        wait_results_drained();
        set_limits('1 - TW'(1), PW'(1000), PW'(2000), PW'(1500));
        repeat (2) send_tick();
        wait_results_drained();
        calm = 1'b0;
    endtask

    task automatic test_random_traffic(input int target);
        int start;
        start = items_sent;
        while (items_sent - start < target)
        begin
            send_random_line();
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 20)) send_tick();
        end
        wait_results_drained();
    endtask

    initial
    begin
        int n;
        out_ready = 1'b1;
        forever
        begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 9) == 0)
            begin
                n = $urandom_range(1, 14);
                out_ready <= 1'b0;
                repeat (n) @(negedge clk);
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        servo_out_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (widths_due.size() == 0)
            begin
                $error("result with no item outstanding");
                fails++;
            end
            else
            begin
                e = widths_due.pop_front();
                if (throttle_us !== e.throttle)
                begin
                    $error("throttle_us expected %0d got %0d", e.throttle, throttle_us);
                    fails++;
                end
                if (steering_us !== e.steering)
                begin
                    $error("steering_us expected %0d got %0d", e.steering, steering_us);
                    fails++;
                end
                if (command_taken !== e.taken)
                begin
                    $error("command_taken expected %0b got %0b", e.taken, command_taken);
                    fails++;
                end
                if (timed_out !== e.fired)
                begin
                    $error("timed_out expected %0b got %0b", e.fired, timed_out);
                    fails++;
                end
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("servo_command_line_parser regression: fail");
        $finish;
    end

    initial
    begin
        clk        = 1'b0;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        opcode     = OP_BYTE;
        rx_byte    = '0;
        cfg_valid  = 1'b0;
        cfg_index  = CFG_TIMEOUT;
        cfg_data   = '0;
        calm       = 1'b0;
        items_sent = 0;
        fails      = 0;

        lim_timeout = TW'(500);
        lim_min     = PW'(1000);
        lim_max     = PW'(2000);
        lim_neutral = PW'(1500);
        clear_line();
        thr_w       = PW'(1500);
        str_w       = PW'(1500);
        quiet_ticks = '0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_line_syntax();
        test_clamp_timing();
        test_timeout_fallback();
        test_long_timeout();
        repeat (5)
        begin
            pick_random_limits();
            test_random_traffic(70);
        end
        calm = 1'b1;
        pick_random_limits();
        test_random_traffic(80);

        repeat (8) @(posedge clk);
        if (widths_due.size() != 0)
        begin
            $error("%0d results never arrived", widths_due.size());
            fails++;
        end
        if (fails == 0)
            $display("servo_command_line_parser regression: pass");
        else
            $display("servo_command_line_parser regression: fail");
        $finish;
    end

endmodule
